/* rtl/efd_pkg.sv */
// Package for the escaped frame deframer: byte codes, state and status types,
// result record and output queue sizing. No dependencies.
package efd_pkg;

    localparam int MAX_FRAME   = 4096;
    localparam int LEN_W       = 13;
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_AW        = $clog2(QUEUE_DEPTH);
    localparam int Q_CW        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] FLAG_OPEN  = 8'h5b;
    localparam logic [7:0] FLAG_CLOSE = 8'h5d;
    localparam logic [7:0] ESC_OPEN   = 8'h5a;
    localparam logic [7:0] ESC_CLOSE  = 8'h5e;
    localparam logic [7:0] SUB_FLAG   = 8'h01;
    localparam logic [7:0] SUB_SELF   = 8'h02;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_FRAME = 2'd1,
        MODE_ESC   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_FMT = 2'd1,
        ST_OVF = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_start;
        logic       frame_end;
        status_t    status;
        logic       last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } core_out_t;

endpackage

/* rtl/efd_core.sv */
// Deframer state and per-beat decode: turns one raw byte into up to two results.
// Depends on efd_pkg.
module efd_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic [7:0]                     rx_byte,
    input  logic [efd_pkg::LEN_W-1:0]      max_len,
    output efd_pkg::core_out_t             res
);

    efd_pkg::mode_t                 mode_reg, mode_next;
    logic                           pesc_reg, pesc_next;
    logic [efd_pkg::LEN_W-1:0]      cnt_reg, cnt_next;
    logic [efd_pkg::LEN_W-1:0]      lim;

    // one byte of the current frame, with length check
    function automatic void frame_step(
        input  efd_pkg::mode_t            m_in,
        input  logic [efd_pkg::LEN_W-1:0] c,
        input  logic [efd_pkg::LEN_W-1:0] l,
        input  logic [7:0]                b,
        input  logic                      is_end,
        output efd_pkg::mode_t            m_o,
        output logic                      p_o,
        output logic [efd_pkg::LEN_W-1:0] c_o,
        output efd_pkg::result_t          r
    );
        r = '0;
        r.out_byte = b;
        m_o = m_in;
        p_o = 1'b0;
        if (c >= l) begin
            m_o = efd_pkg::MODE_IDLE;
            c_o = '0;
            r.status = efd_pkg::ST_OVF;
        end else if (is_end) begin
            m_o = efd_pkg::MODE_IDLE;
            c_o = '0;
            r.frame_end = 1'b1;
        end else begin
            c_o = c + 1'b1;
        end
    endfunction

    // byte with no escape pending
    function automatic void plain_step(
        input  efd_pkg::mode_t            m_in,
        input  logic                      p_in,
        input  logic [efd_pkg::LEN_W-1:0] c,
        input  logic [efd_pkg::LEN_W-1:0] l,
        input  logic [7:0]                b,
        output efd_pkg::mode_t            m_o,
        output logic                      p_o,
        output logic [efd_pkg::LEN_W-1:0] c_o,
        output logic                      emit,
        output efd_pkg::result_t          r
    );
        r = '0;
        r.out_byte = b;
        m_o = m_in;
        p_o = p_in;
        c_o = c;
        emit = 1'b1;
        if (m_in != efd_pkg::MODE_FRAME) begin
            if (b == efd_pkg::FLAG_OPEN) begin
                m_o = efd_pkg::MODE_FRAME;
                p_o = 1'b0;
                c_o = efd_pkg::LEN_W'(1);
                r.frame_start = 1'b1;
            end else begin
                m_o = efd_pkg::MODE_IDLE;
                r.status = efd_pkg::ST_FMT;
            end
        end else if (b == efd_pkg::FLAG_CLOSE) begin
            frame_step(m_in, c, l, b, 1'b1, m_o, p_o, c_o, r);
        end else if (b == efd_pkg::ESC_OPEN || b == efd_pkg::ESC_CLOSE) begin
            m_o = efd_pkg::MODE_ESC;
            p_o = (b == efd_pkg::ESC_CLOSE);
            emit = 1'b0;
        end else begin
            frame_step(m_in, c, l, b, 1'b0, m_o, p_o, c_o, r);
        end
    endfunction

    always_comb
    begin
        if (max_len > efd_pkg::LEN_W'(efd_pkg::MAX_FRAME))
            lim = efd_pkg::LEN_W'(efd_pkg::MAX_FRAME);
        else if (max_len < efd_pkg::LEN_W'(2))
            lim = efd_pkg::LEN_W'(2);
        else
            lim = max_len;
    end

    always_comb
    begin
        efd_pkg::mode_t            m1;
        logic                      p1;
        logic [efd_pkg::LEN_W-1:0] c1;
        logic [7:0]                esc;
        logic                      emit;
        efd_pkg::result_t          ra;
        efd_pkg::result_t          rb;

        m1 = mode_reg;
        p1 = pesc_reg;
        c1 = cnt_reg;
        emit = 1'b0;
        ra = '0;
        rb = '0;
        esc = pesc_reg ? efd_pkg::ESC_CLOSE : efd_pkg::ESC_OPEN;
        res = '0;
        mode_next = mode_reg;
        pesc_next = pesc_reg;
        cnt_next = cnt_reg;

        if (mode_reg == efd_pkg::MODE_ESC) begin
            if (rx_byte == efd_pkg::SUB_FLAG) begin
                frame_step(efd_pkg::MODE_FRAME, cnt_reg, lim,
                           pesc_reg ? efd_pkg::FLAG_CLOSE : efd_pkg::FLAG_OPEN,
                           1'b0, mode_next, pesc_next, cnt_next, ra);
                res.count = 2'd1;
                res.r0 = ra;
            end else if (rx_byte == efd_pkg::SUB_SELF) begin
                frame_step(efd_pkg::MODE_FRAME, cnt_reg, lim, esc, 1'b0,
                           mode_next, pesc_next, cnt_next, ra);
                res.count = 2'd1;
                res.r0 = ra;
            end else begin
                frame_step(efd_pkg::MODE_FRAME, cnt_reg, lim, esc, 1'b0, m1, p1, c1, ra);
                plain_step(m1, p1, c1, lim, rx_byte,
                           mode_next, pesc_next, cnt_next, emit, rb);
                res.r0 = ra;
                res.r1 = rb;
                res.count = emit ? 2'd2 : 2'd1;
            end
        end else begin
            plain_step(mode_reg, pesc_reg, cnt_reg, lim, rx_byte,
                       mode_next, pesc_next, cnt_next, emit, ra);
            res.r0 = ra;
            res.count = emit ? 2'd1 : 2'd0;
        end

        // mark the final result of this beat
        if (res.count == 2'd2)
            res.r1.last_of_run = 1'b1;
        else
            res.r0.last_of_run = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= efd_pkg::MODE_IDLE;
            pesc_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (accept) begin
            mode_reg <= mode_next;
            pesc_reg <= pesc_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

/* rtl/efd_outq.sv */
// Result queue: takes up to two results per beat, hands out one per beat while out_ready is high.
// Depends on efd_pkg.
module efd_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  efd_pkg::core_out_t  din,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output efd_pkg::result_t    dout
);

    efd_pkg::result_t           mem_reg [efd_pkg::QUEUE_DEPTH];
    logic [efd_pkg::Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [efd_pkg::Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [efd_pkg::Q_CW-1:0]   cnt_reg, cnt_next;
    logic [1:0]                 n_push;
    logic                       pop;
    logic [efd_pkg::Q_AW-1:0]   wr_ptr_p1;

    assign room      = cnt_reg <= efd_pkg::Q_CW'(efd_pkg::QUEUE_DEPTH - 2);
    assign out_valid = cnt_reg != '0;
    assign pop       = out_valid && out_ready;
    assign dout      = mem_reg[rd_ptr_reg];
    assign n_push    = push ? din.count : 2'd0;
    assign wr_ptr_p1 = efd_pkg::Q_AW'(wr_ptr_reg + 1'b1);

    always_comb
    begin
        wr_ptr_next = efd_pkg::Q_AW'(wr_ptr_reg + n_push);
        rd_ptr_next = pop ? efd_pkg::Q_AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        cnt_next    = efd_pkg::Q_CW'(cnt_reg + n_push - {{(efd_pkg::Q_CW-1){1'b0}}, pop});
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            mem_reg[wr_ptr_reg] <= din.r0;
        if (n_push == 2'd2)
            mem_reg[wr_ptr_p1] <= din.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* rtl/escaped_frame_deframer.sv */
// Top level of the escaped frame deframer: config register, decode core and
// result queue. Depends on efd_pkg, efd_core, efd_outq.
//
// Usage:
//   Input beats (in_valid/in_ready, rx_byte) carry one raw link byte each.
//   Output beats (out_valid/out_ready) carry one result: out_byte,
//   frame_start, frame_end, status and last_of_run. A byte yields zero
//   (escape byte), one, or two results (failed escape pair).
//   cfg_we/cfg_wdata write max_frame_len; write it only while idle.
//   Results are registered in the queue; a result is offered once the results ahead of it have left.
//   Throughput: one input byte per cycle while each byte gives at most one
//   result and out_ready stays high; a byte with two results is drained
//   through the single output port from the four-entry result queue.
//   in_ready is high while the queue has room for two results, so a new
//   byte is taken even while a result waits for out_ready.
//   When the receiver stalls, results stay in the queue and in_ready drops
//   once fewer than two entries are free; nothing is lost.
//   Reset: deframer is idle outside any frame, queue is empty and
//   max_frame_len returns to 4096.
module escaped_frame_deframer (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [efd_pkg::LEN_W-1:0]  cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 rx_byte,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [7:0]                 out_byte,
    output logic                       frame_start,
    output logic                       frame_end,
    output logic [1:0]                 status,
    output logic                       last_of_run
);

    logic [efd_pkg::LEN_W-1:0] max_len_reg;
    logic                      accept;
    efd_pkg::core_out_t        core_res;
    efd_pkg::result_t          q_out;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= efd_pkg::LEN_W'(efd_pkg::MAX_FRAME);
        else if (cfg_we)
            max_len_reg <= cfg_wdata;
    end

    efd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .max_len (max_len_reg),
        .res     (core_res)
    );

    efd_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .din       (core_res),
        .room      (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dout      (q_out)
    );

    assign out_byte    = q_out.out_byte;
    assign frame_start = q_out.frame_start;
    assign frame_end   = q_out.frame_end;
    assign status      = q_out.status;
    assign last_of_run = q_out.last_of_run;

endmodule

/* rtl/efd_checker.sv */
// Port-level checks for escaped_frame_deframer, attached by bind.
// Depends on efd_pkg.
module efd_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [7:0]                 out_byte,
    input  logic                       frame_start,
    input  logic                       frame_end,
    input  logic [1:0]                 status,
    input  logic                       last_of_run
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat dropped while stalled");

    // second result of a byte is already queued
    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid)
        else $error("second result of a byte missing");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_start |-> out_byte == efd_pkg::FLAG_OPEN && !frame_end
            && status == efd_pkg::ST_OK && last_of_run)
        else $error("bad frame start beat");

    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> out_byte == efd_pkg::FLAG_CLOSE
            && status == efd_pkg::ST_OK && last_of_run)
        else $error("bad frame end beat");

    a_fmt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == efd_pkg::ST_FMT |-> last_of_run && !frame_start && !frame_end)
        else $error("bad format error beat");

endmodule

bind escaped_frame_deframer efd_checker u_efd_checker (.*);
